/* src/bgauge_pkg.sv */
// Shared types and constants for the battery gauge step block.
// No dependencies; imported by battery_gauge_step_top and bgauge_chk.
package bgauge_pkg;

  // Field widths
  localparam int BUS_W    = 16;
  localparam int SHUNT_W  = 16;
  localparam int MV_W     = 17;
  localparam int PCT_W    = 7;
  localparam int THR_W    = 17;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 17;

  // Divider sizing: numerator is at most 1100 * 10 = 11000
  localparam int DIV_W     = 14;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_POLARITY  = 1'b1;

  // Reset values
  localparam logic [THR_W-1:0] THRESHOLD_RESET = 17'd200;
  localparam logic             POLARITY_RESET  = 1'b1;

  // Discharge curve: voltage breakpoints and percent at each
  localparam int CURVE_PTS = 8;
  localparam logic [MV_W-1:0] CURVE_MV [CURVE_PTS] = '{
    17'd6000, 17'd7100, 17'd7320, 17'd7480,
    17'd7700, 17'd7900, 17'd8140, 17'd8300
  };
  localparam logic [PCT_W-1:0] CURVE_PC [CURVE_PTS] = '{
    7'd0, 7'd10, 7'd20, 7'd40, 7'd60, 7'd75, 7'd90, 7'd100
  };
  localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_SEG,
    ST_DIV,
    ST_FIN
  } bgauge_state_t;

endpackage

/* src/battery_gauge_step_top.sv */
// Battery gauge step: raw monitor readings to charge flag, smoothed mV and percent.
// Depends on bgauge_pkg for widths, register codes, curve table and state type.
// A result shows on out_valid after the input passes CALC, SEG, the divide steps and FIN.
// One item at a time: the 14-step shift/subtract divider that interpolates the curve
// finishes before the next item is taken, and in_ready is high only while idle.
// Reset (synchronous, active high): threshold 200 uV, negative polarity, average
// cleared to unseeded, no result pending.
module battery_gauge_step_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [bgauge_pkg::BUS_W-1:0]         bus_raw,
  input  logic signed [bgauge_pkg::SHUNT_W-1:0] shunt_raw,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 charging,
  output logic [bgauge_pkg::MV_W-1:0]          avg_millivolts,
  output logic [bgauge_pkg::PCT_W-1:0]         percent,
  input  logic                                 cfg_we,
  input  logic [bgauge_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bgauge_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import bgauge_pkg::*;

  bgauge_state_t state, state_next;

  // Configuration and persistent state
  logic [THR_W-1:0] threshold;
  logic             polarity;
  logic [MV_W-1:0]  smoothed;

  // Captured transaction and work registers
  logic [BUS_W-1:0]          bus_r;
  logic signed [SHUNT_W-1:0] shunt_r;
  logic                      charge_r;
  logic [PCT_W-1:0]          base_pct;
  logic [DIV_W-1:0]          div_den;
  logic [DIV_W-1:0]          div_rem;
  logic [DIV_W-1:0]          div_q;
  logic [DIV_CNT_W-1:0]      div_cnt;

  // Conversion and averaging datapath
  logic [18:0]        bus_x5;
  logic [MV_W-1:0]    bus_mv;
  logic signed [18:0] shunt_x5;
  logic signed [18:0] shunt_micro;
  logic signed [18:0] signed_uv;
  logic               charge_calc;
  logic signed [18:0] avg_diff;
  logic signed [18:0] avg_step;
  logic signed [18:0] avg_sum;
  logic [MV_W-1:0]    avg_new;

  // Curve segment datapath
  logic [2:0]        seg_idx;
  logic [MV_W-1:0]   seg_off;
  logic [PCT_W-1:0]  seg_rise;
  logic [MV_W-1:0]   seg_span;
  logic [DIV_W-1:0]  seg_num;
  logic [PCT_W-1:0]  seg_base;
  logic [DIV_W-1:0]  seg_den;
  logic [DIV_W-1:0]  seg_numsel;
  logic [20:0]       seg_prod;

  // Divider step
  logic [DIV_W:0]    div_trial;
  logic              div_bit;

  // Rounding
  logic [PCT_W-1:0]  pct_raw;
  logic [PCT_W-1:0]  pct_p2;
  logic [14:0]       pct_scaled;
  logic [4:0]        pct_fives;
  logic [PCT_W-1:0]  pct_round;
  logic [PCT_W-1:0]  pct_final;

  // Convert raw counts; bus * 5 / 4 and shunt * 5 / 2 toward zero
  always_comb begin
    bus_x5      = {1'b0, bus_r, 2'b00} + {3'b000, bus_r};
    bus_mv      = bus_x5[18:2];
    shunt_x5    = (19'(shunt_r) <<< 2) + 19'(shunt_r);
    shunt_micro = (shunt_x5 + ((shunt_x5 < 0) ? 19'sd1 : 19'sd0)) >>> 1;
    signed_uv   = polarity ? -shunt_micro : shunt_micro;
    charge_calc = signed_uv > $signed({2'b00, threshold});
    avg_diff    = $signed({2'b00, bus_mv}) - $signed({2'b00, smoothed});
    avg_step    = (avg_diff + ((avg_diff < 0) ? 19'sd7 : 19'sd0)) >>> 3;
    avg_sum     = $signed({2'b00, smoothed}) + avg_step;
    avg_new     = (smoothed == '0) ? bus_mv : avg_sum[MV_W-1:0];
  end

  // Pick the curve segment holding the stored average
  always_comb begin
    seg_idx = 3'd7;
    for (int i = CURVE_PTS - 1; i >= 1; i--) begin
      if (smoothed <= CURVE_MV[i]) seg_idx = 3'(i);
    end
    seg_off  = smoothed - CURVE_MV[seg_idx - 3'd1];
    seg_rise = CURVE_PC[seg_idx] - CURVE_PC[seg_idx - 3'd1];
    seg_span = CURVE_MV[seg_idx] - CURVE_MV[seg_idx - 3'd1];
    seg_prod = 21'(seg_off[10:0]) * 21'(seg_rise[4:0]);
    seg_num  = seg_prod[DIV_W-1:0];
    if (smoothed <= CURVE_MV[0]) begin
      seg_base   = CURVE_PC[0];
      seg_numsel = '0;
      seg_den    = DIV_W'(1);
    end else if (smoothed >= CURVE_MV[CURVE_PTS-1]) begin
      seg_base   = CURVE_PC[CURVE_PTS-1];
      seg_numsel = '0;
      seg_den    = DIV_W'(1);
    end else begin
      seg_base   = CURVE_PC[seg_idx - 3'd1];
      seg_numsel = seg_num;
      seg_den    = seg_span[DIV_W-1:0];
    end
  end

  // One restoring divide step
  always_comb begin
    div_trial = {div_rem, div_q[DIV_W-1]};
    div_bit   = div_trial >= {1'b0, div_den};
  end

  // Round to a multiple of five: floor(x / 5) as x * 205 >> 10 for x <= 102
  always_comb begin
    pct_raw    = base_pct + div_q[PCT_W-1:0];
    pct_p2     = pct_raw + 7'd2;
    pct_scaled = 15'(pct_p2) * 15'd205;
    pct_fives  = pct_scaled[14:10];
    pct_round  = {pct_fives, 2'b00} + {2'b00, pct_fives};
    pct_final  = (pct_round > PCT_MAX) ? PCT_MAX : pct_round;
  end

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshake
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = ST_CALC;
      end
      ST_CALC: state_next = ST_SEG;
      ST_SEG:  state_next = ST_DIV;
      ST_DIV: begin
        if (div_cnt == '0) state_next = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid || out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
      polarity  <= POLARITY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THRESHOLD: threshold <= cfg_data[THR_W-1:0];
        REG_POLARITY:  polarity  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Average state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      smoothed  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_CALC) smoothed <= avg_new;
      if (state == ST_FIN && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Work registers: capture, segment setup, divide iterations, result load
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        bus_r   <= bus_raw;
        shunt_r <= shunt_raw;
      end
      ST_CALC: charge_r <= charge_calc;
      ST_SEG: begin
        base_pct <= seg_base;
        div_den  <= seg_den;
        div_q    <= seg_numsel;
        div_rem  <= '0;
        div_cnt  <= DIV_CNT_W'(DIV_W - 1);
      end
      ST_DIV: begin
        div_rem <= div_bit ? DIV_W'(div_trial - {1'b0, div_den}) : div_trial[DIV_W-1:0];
        div_q   <= {div_q[DIV_W-2:0], div_bit};
        div_cnt <= div_cnt - 1'b1;
      end
      ST_FIN: begin
        if (!out_valid || out_ready) begin
          charging       <= charge_r;
          avg_millivolts <= smoothed;
          percent        <= pct_final;
        end
      end
      default: ;
    endcase
  end

endmodule

/* src/bgauge_chk.sv */
// Port-level checker for battery_gauge_step_top, attached by bind.
// Depends on bgauge_pkg for field widths and PCT_MAX.
module bgauge_chk (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  in_valid,
  input logic                                  in_ready,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic                                  charging,
  input logic [bgauge_pkg::MV_W-1:0]           avg_millivolts,
  input logic [bgauge_pkg::PCT_W-1:0]          percent
);
  import bgauge_pkg::*;

  // Reset leaves no result pending
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set right after reset");

  // Block is busy the cycle after taking a transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready high right after an input transaction");

  // A stalled result holds
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(percent)
      && $stable(avg_millivolts) && $stable(charging)))
    else $error("stalled result changed");

  // Percent stays within the curve range
  a_percent_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (percent <= PCT_MAX))
    else $error("percent above 100");

endmodule

bind battery_gauge_step_top bgauge_chk u_bgauge_chk (.*);
